>>> hdl/neighbor_table_aging_eviction_unit_assert.svh
// ---------------------------------------------------------------------------
// Neighbor table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_AGING_EVICTION_UNIT_ASSERT_SVH
`define NEIGHBOR_TABLE_AGING_EVICTION_UNIT_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define NTAE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define NTAE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/ntae_pkg.sv
// ---------------------------------------------------------------------------
// Neighbor table package
// Operation codes, register indexes, constants and the control interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntae_pkg;

	localparam logic [1:0] FUNC_BEACON = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_FIND   = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	localparam logic REG_OWN_ID  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [31:0] TIMEOUT_RESET    = 32'd30000;
	localparam logic [7:0]  MIN_BEACON_BYTES = 8'd24;

	localparam int SLOT_BITS  = 3;
	localparam int COUNT_BITS = 4;
	localparam int IN_BITS    = 80;
	localparam int OUT_BITS   = 80;
	localparam int RES_BITS   = 78;

	typedef struct packed {
		logic capture;
		logic issue;
		logic issue_sel;
		logic eval;
		logic mark_ignore;
		logic mark_match;
		logic mark_none;
		logic mark_read;
		logic refresh;
		logic append;
		logic evict;
		logic tick_end;
		logic emit;
	} ntae_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       ignore;
		logic       empty;
		logic       full;
		logic       more;
		logic       match;
		logic       last;
		logic       out_free;
	} ntae_sts_t;

endpackage

`default_nettype wire

>>> hdl/ntae_ctrl.sv
// ---------------------------------------------------------------------------
// Neighbor table controller
// Sequences capture, table walk, table update and result transfer per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntae_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  ntae_pkg::ntae_sts_t sts,
	output ntae_pkg::ntae_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_SCAN     = 4'd2;
	localparam logic [3:0] ST_RDSEL    = 4'd3;
	localparam logic [3:0] ST_RDDATA   = 4'd4;
	localparam logic [3:0] ST_REFRESH  = 4'd5;
	localparam logic [3:0] ST_APPEND   = 4'd6;
	localparam logic [3:0] ST_EVICT    = 4'd7;
	localparam logic [3:0] ST_TICKEND  = 4'd8;
	localparam logic [3:0] ST_EMIT     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.func)
					ntae_pkg::FUNC_BEACON: begin
						if (sts.ignore) begin
							cmd.mark_ignore = 1'b1;
							state_nxt       = ST_EMIT;
						end else if (sts.empty) begin
							state_nxt = ST_APPEND;
						end else begin
							state_nxt = ST_SCAN;
						end
					end
					ntae_pkg::FUNC_TICK: begin
						state_nxt = sts.empty ? ST_TICKEND : ST_SCAN;
					end
					ntae_pkg::FUNC_FIND: begin
						if (sts.empty) begin
							cmd.mark_none = 1'b1;
							state_nxt     = ST_EMIT;
						end else begin
							state_nxt = ST_SCAN;
						end
					end
					ntae_pkg::FUNC_READ: begin
						state_nxt = ST_RDSEL;
					end
					default: begin
						state_nxt = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.issue = sts.more;
				cmd.eval  = 1'b1;
				if (sts.func != ntae_pkg::FUNC_TICK && sts.match) begin
					cmd.mark_match = 1'b1;
					state_nxt = (sts.func == ntae_pkg::FUNC_FIND) ? ST_EMIT : ST_REFRESH;
				end else if (sts.last) begin
					case (sts.func)
						ntae_pkg::FUNC_FIND: begin
							cmd.mark_none = 1'b1;
							state_nxt     = ST_EMIT;
						end
						ntae_pkg::FUNC_BEACON: begin
							state_nxt = sts.full ? ST_EVICT : ST_APPEND;
						end
						default: begin
							state_nxt = ST_TICKEND;
						end
					endcase
				end
			end
			ST_RDSEL: begin
				cmd.issue_sel = 1'b1;
				state_nxt     = ST_RDDATA;
			end
			ST_RDDATA: begin
				cmd.mark_read = 1'b1;
				state_nxt     = ST_EMIT;
			end
			ST_REFRESH: begin
				cmd.refresh = 1'b1;
				state_nxt   = ST_EMIT;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_nxt  = ST_EMIT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_TICKEND: begin
				cmd.tick_end = 1'b1;
				state_nxt    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ntae_dp.sv
// ---------------------------------------------------------------------------
// Neighbor table datapath
// Entry memory, configuration, walk counters, compare logic and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "neighbor_table_aging_eviction_unit_assert.svh"

module ntae_dp #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ntae_pkg::ntae_cmd_t              cmd,
	output ntae_pkg::ntae_sts_t              sts,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [31:0]                      cfg_wdata,
	input  logic [ntae_pkg::IN_BITS-1:0]     s_tdata,
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ntae_pkg::OUT_BITS-1:0]    m_tdata
);

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int SB   = ntae_pkg::SLOT_BITS;
	localparam int NB   = ntae_pkg::COUNT_BITS;
	localparam int CMPW = (CW > SB) ? CW : SB;
	localparam int RB   = ntae_pkg::RES_BITS;

	logic [63:0]   ent_mem [TABLE_DEPTH];

	logic [31:0]   own_q;
	logic [31:0]   timeout_q;
	logic [CW-1:0] count_q;

	logic [1:0]    func_q;
	logic [31:0]   key_q;
	logic [31:0]   now_q;
	logic [7:0]    plen_q;
	logic [SB-1:0] sel_q;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] removed_q;
	logic [31:0]   best_q;
	logic [AW-1:0] best_slot_q;
	logic [AW-1:0] at_q;

	logic          rvld_s1;
	logic [CW-1:0] ridx_s1;
	logic [63:0]   rdata_s1;

	logic          p_hit_q;
	logic [SB-1:0] p_slot_q;
	logic [31:0]   p_id_q;
	logic [31:0]   p_seen_q;
	logic [NB-1:0] p_expired_q;
	logic          p_evicted_q;
	logic          p_ignored_q;

	logic          m_tvalid_q;
	logic [RB-1:0] out_q;

	logic [31:0]   rid;
	logic [31:0]   rseen;
	logic [31:0]   age;
	logic          expired;
	logic          sel_ok;
	logic          tick_eval;
	logic          we;
	logic [AW-1:0] waddr;
	logic [63:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;

	assign rid       = rdata_s1[63:32];
	assign rseen     = rdata_s1[31:0];
	assign age       = now_q - rseen;
	assign expired   = age > timeout_q;
	assign sel_ok    = CMPW'(sel_q) < CMPW'(count_q);
	assign tick_eval = cmd.eval && rvld_s1 && (func_q == ntae_pkg::FUNC_TICK);

	assign sts.func     = func_q;
	assign sts.ignore   = (plen_q < ntae_pkg::MIN_BEACON_BYTES) || (key_q == own_q);
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(TABLE_DEPTH));
	assign sts.more     = (idx_q < count_q);
	assign sts.match    = rvld_s1 && (rid == key_q);
	assign sts.last     = rvld_s1 && ((ridx_s1 + 1'b1) == count_q);
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = {key_q, now_q};
		if (tick_eval && !expired) begin
			we    = 1'b1;
			waddr = wr_q[AW-1:0];
			wdata = rdata_s1;
		end
		if (cmd.refresh) begin
			we    = 1'b1;
			waddr = at_q;
		end
		if (cmd.append) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
		end
		if (cmd.evict) begin
			we    = 1'b1;
			waddr = best_slot_q;
		end
	end

	assign re    = cmd.issue || cmd.issue_sel;
	assign raddr = cmd.issue_sel ? AW'(sel_q) : idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			ent_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= ent_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q      <= '0;
			timeout_q  <= ntae_pkg::TIMEOUT_RESET;
			count_q    <= '0;
			idx_q      <= '0;
			wr_q       <= '0;
			rvld_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ntae_pkg::REG_OWN_ID) begin
					own_q <= cfg_wdata;
				end else begin
					timeout_q <= cfg_wdata;
				end
			end
			rvld_s1 <= cmd.issue;
			if (cmd.capture) begin
				idx_q <= '0;
				wr_q  <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (tick_eval && !expired) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd.append) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.tick_end) begin
				count_q <= wr_q;
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q      <= s_tuser;
			key_q       <= s_tdata[31:0];
			now_q       <= s_tdata[63:32];
			plen_q      <= s_tdata[71:64];
			sel_q       <= s_tdata[74:72];
			removed_q   <= '0;
			best_q      <= '1;
			best_slot_q <= '0;
		end
		if (cmd.issue) begin
			ridx_s1 <= idx_q;
		end
		if (tick_eval && expired) begin
			removed_q <= removed_q + 1'b1;
		end
		if (cmd.eval && rvld_s1 && func_q == ntae_pkg::FUNC_BEACON && rseen < best_q) begin
			best_q      <= rseen;
			best_slot_q <= ridx_s1[AW-1:0];
		end
		if (cmd.mark_ignore || cmd.mark_none || cmd.tick_end) begin
			p_hit_q     <= 1'b0;
			p_slot_q    <= '0;
			p_id_q      <= '0;
			p_seen_q    <= '0;
			p_evicted_q <= 1'b0;
			p_ignored_q <= cmd.mark_ignore;
			p_expired_q <= cmd.tick_end ? NB'(removed_q) : '0;
		end
		if (cmd.mark_match) begin
			at_q        <= ridx_s1[AW-1:0];
			p_hit_q     <= 1'b1;
			p_slot_q    <= SB'(ridx_s1);
			p_id_q      <= rid;
			p_seen_q    <= rseen;
			p_evicted_q <= 1'b0;
			p_ignored_q <= 1'b0;
			p_expired_q <= '0;
		end
		if (cmd.mark_read) begin
			p_hit_q     <= sel_ok;
			p_slot_q    <= sel_q;
			p_id_q      <= sel_ok ? rid : '0;
			p_seen_q    <= sel_ok ? rseen : '0;
			p_evicted_q <= 1'b0;
			p_ignored_q <= 1'b0;
			p_expired_q <= '0;
		end
		if (cmd.refresh) begin
			p_seen_q <= now_q;
		end
		if (cmd.append || cmd.evict) begin
			p_hit_q     <= 1'b0;
			p_slot_q    <= cmd.evict ? SB'(best_slot_q) : SB'(count_q);
			p_id_q      <= key_q;
			p_seen_q    <= now_q;
			p_evicted_q <= cmd.evict;
			p_ignored_q <= 1'b0;
			p_expired_q <= '0;
		end
		if (cmd.emit) begin
			out_q <= {p_ignored_q, p_evicted_q, p_expired_q, NB'(count_q),
				p_seen_q, p_id_q, p_slot_q, p_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ntae_pkg::OUT_BITS - RB){1'b0}}, out_q};

	`NTAE_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(TABLE_DEPTH), "entry count beyond table depth")
	`NTAE_ASSERT_IMPL(a_pack_order, tick_eval, wr_q <= ridx_s1, "compaction write passed read")
	`NTAE_ASSERT_IMPL(a_evict_full, p_evicted_q, count_q == CW'(TABLE_DEPTH), "eviction on non-full table")
	`NTAE_ASSERT_IMPL(a_ignore_clean, m_tvalid_q && out_q[77], !out_q[0] && !out_q[76], "ignored beacon reports hit or eviction")

endmodule

`default_nettype wire

>>> hdl/neighbor_table_aging_eviction_unit.sv
// The time from input transfer to result grows with the entry count N, set by the table walk
// that reads one entry per cycle. Items are handled one at a time.
// A waiting result does not block the next input transfer; it blocks only the next result.
// Reset clears the entry count, the controller and the output valid; entry contents are
// undefined until written, and the timeout register resets to 30000.
// ---------------------------------------------------------------------------
// Neighbor table with aging and eviction
// Top level: stream input and output, configuration writes, controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module neighbor_table_aging_eviction_unit #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// node_id[31:0], now_ms[63:32], payload_length[71:64], slot_select[74:72], zero fill
	input  logic [ntae_pkg::IN_BITS-1:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit[0], slot_index[3:1], entry_id[35:4], entry_seen_ms[67:36], peer_count[71:68],
	// expired_count[75:72], evicted[76], ignored[77], zero fill
	output logic [ntae_pkg::OUT_BITS-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [31:0]                   cfg_wdata
);

	ntae_pkg::ntae_cmd_t cmd;
	ntae_pkg::ntae_sts_t sts;

	ntae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ntae_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// ---------------------------------------------------------------------------
// Neighbor table aging and eviction testbench
// Drives beacon, tick, find and read operations through the stream input with
// random gaps and a long output hold-off, predicts every result from a local
// copy of the table and configuration, and checks each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH        = 8;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] id;
		logic [31:0] now;
		logic [7:0]  plen;
		logic [2:0]  sel;
	} op_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  slot;
		logic [31:0] id;
		logic [31:0] seen;
		logic [3:0]  count;
		logic [3:0]  expired;
		logic        evicted;
		logic        ignored;
	} reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [ntae_pkg::IN_BITS-1:0]  s_tdata = '0;
	logic [1:0]                    s_tuser = ntae_pkg::FUNC_BEACON;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ntae_pkg::OUT_BITS-1:0] m_tdata;
	logic                          cfg_we = 1'b0;
	logic                          cfg_index = ntae_pkg::REG_OWN_ID;
	logic [31:0]                   cfg_wdata = '0;

	op_t         pending_ops[$];
	reply_t      expected_replies[$];

	logic [31:0] nbr_id[DEPTH];
	logic [31:0] nbr_seen[DEPTH];
	int          nbr_count = 0;
	logic [31:0] own_id = '0;
	logic [31:0] timeout_ms = ntae_pkg::TIMEOUT_RESET;

	int          errors = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          in_gap = 0;
	int          out_gap = 0;
	bit          offering = 1'b0;
	bit          rdy = 1'b0;

	neighbor_table_aging_eviction_unit #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int find_slot(logic [31:0] id);
		for (int i = 0; i < nbr_count; i++)
			if (nbr_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic reply_t table_predict(op_t op);
		reply_t      r;
		int          pos;
		int          kept;
		int          gone;
		logic [31:0] best;
		r = '0;
		case (op.func)
			ntae_pkg::FUNC_BEACON: begin
				if (op.plen < ntae_pkg::MIN_BEACON_BYTES || op.id == own_id) begin
					r.ignored = 1'b1;
				end else begin
					pos = find_slot(op.id);
					if (pos >= 0) begin
						r.hit = 1'b1;
					end else if (nbr_count < DEPTH) begin
						pos = nbr_count;
						nbr_count++;
					end else begin
						best = 32'hFFFF_FFFF;
						pos = 0;
						for (int i = 0; i < DEPTH; i++) begin
							if (nbr_seen[i] < best) begin
								best = nbr_seen[i];
								pos = i;
							end
						end
						r.evicted = 1'b1;
					end
					nbr_id[pos] = op.id;
					nbr_seen[pos] = op.now;
					r.slot = pos[2:0];
					r.id = nbr_id[pos];
					r.seen = nbr_seen[pos];
				end
			end
			ntae_pkg::FUNC_TICK: begin
				kept = 0;
				gone = 0;
				for (int i = 0; i < nbr_count; i++) begin
					if (32'(op.now - nbr_seen[i]) > timeout_ms) begin
						gone++;
					end else begin
						nbr_id[kept] = nbr_id[i];
						nbr_seen[kept] = nbr_seen[i];
						kept++;
					end
				end
				nbr_count = kept;
				r.expired = gone[3:0];
			end
			ntae_pkg::FUNC_FIND: begin
				pos = find_slot(op.id);
				if (pos >= 0) begin
					r.hit = 1'b1;
					r.slot = pos[2:0];
					r.id = nbr_id[pos];
					r.seen = nbr_seen[pos];
				end
			end
			default: begin
				r.slot = op.sel;
				if (op.sel < nbr_count) begin
					r.hit = 1'b1;
					r.id = nbr_id[op.sel];
					r.seen = nbr_seen[op.sel];
				end
			end
		endcase
		r.count = nbr_count[3:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_reply(input logic [ntae_pkg::OUT_BITS-1:0] d);
		reply_t want;
		reply_t got;
		if (expected_replies.size() == 0) begin
			report_mismatch("result with nothing expected", d[31:0], 32'd0);
			return;
		end
		want = expected_replies.pop_front();
		got = '{hit: d[0], slot: d[3:1], id: d[35:4], seen: d[67:36], count: d[71:68],
			expired: d[75:72], evicted: d[76], ignored: d[77]};
		if (got.hit !== want.hit)
			report_mismatch("hit", 32'(got.hit), 32'(want.hit));
		if (got.slot !== want.slot)
			report_mismatch("slot_index", 32'(got.slot), 32'(want.slot));
		if (got.id !== want.id)
			report_mismatch("entry_id", got.id, want.id);
		if (got.seen !== want.seen)
			report_mismatch("entry_seen_ms", got.seen, want.seen);
		if (got.count !== want.count)
			report_mismatch("peer_count", 32'(got.count), 32'(want.count));
		if (got.expired !== want.expired)
			report_mismatch("expired_count", 32'(got.expired), 32'(want.expired));
		if (got.evicted !== want.evicted)
			report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
		if (got.ignored !== want.ignored)
			report_mismatch("ignored", 32'(got.ignored), 32'(want.ignored));
		if (d[ntae_pkg::OUT_BITS-1:ntae_pkg::RES_BITS] !== '0)
			report_mismatch("zero fill", 32'(d[ntae_pkg::OUT_BITS-1:ntae_pkg::RES_BITS]),
				32'd0);
	endtask

	function automatic int pick_gap();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_replies.push_back(table_predict(pending_ops.pop_front()));
				offering = 1'b0;
				in_gap = pick_gap();
			end
			if (!offering) begin
				if (in_gap > 0)
					in_gap--;
				else if (pending_ops.size() > 0)
					offering = 1'b1;
			end
			s_tvalid <= offering;
			if (offering) begin
				s_tdata <= {5'd0, pending_ops[0].sel, pending_ops[0].plen,
					pending_ops[0].now, pending_ops[0].id};
				s_tuser <= pending_ops[0].func;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_reply(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_gap = pick_gap();
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL neighbor_table_aging_eviction_unit");
				$finish;
			end
		end
	end

	task automatic queue_op(input logic [1:0] func, input logic [31:0] id,
			input logic [31:0] now, input logic [7:0] plen, input logic [2:0] sel);
		op_t op;
		op = '{func: func, id: id, now: now, plen: plen, sel: sel};
		pending_ops.push_back(op);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == ntae_pkg::REG_OWN_ID)
			own_id = val;
		else
			timeout_ms = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Ids come mostly from a small pool that holds the own id, so refreshes,
	// lookups that hit, ignored beacons and evictions of a full table are common.
	task automatic random_phase(input int n_ops, input logic [31:0] step_max);
		logic [31:0] pool[12];
		logic [31:0] now_ms;
		op_t         op;
		int          k;
		pool[0] = own_id;
		pool[1] = 32'd0;
		pool[2] = 32'hFFFF_FFFF;
		for (int i = 3; i < 12; i++)
			pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 40);
		now_ms = $urandom;
		for (int i = 0; i < n_ops; i++) begin
			k = $urandom_range(0, 99);
			op.func = (k < 50) ? ntae_pkg::FUNC_BEACON : (k < 62) ? ntae_pkg::FUNC_TICK :
				(k < 82) ? ntae_pkg::FUNC_FIND : ntae_pkg::FUNC_READ;
			op.id = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 11)] : $urandom;
			now_ms += $urandom_range(0, step_max);
			op.now = ($urandom_range(0, 19) == 0) ? $urandom : now_ms;
			op.plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 23)) :
				8'($urandom_range(24, 255));
			op.sel = 3'($urandom_range(0, 7));
			pending_ops.push_back(op);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_op(ntae_pkg::FUNC_READ, 32'd0, 32'd0, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_READ, '1, '1, '1, 3'd7);
		queue_op(ntae_pkg::FUNC_FIND, 32'd5, 32'd0, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_TICK, 32'd0, 32'd0, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_BEACON, 32'd0, 32'd1, 8'd255, 3'd0);
		queue_op(ntae_pkg::FUNC_BEACON, 32'd1, 32'd1, 8'd23, 3'd0);
		queue_op(ntae_pkg::FUNC_BEACON, 32'd2, 32'd1, 8'd0, 3'd0);
		for (int i = 0; i < DEPTH; i++)
			queue_op(ntae_pkg::FUNC_BEACON, (i == DEPTH - 1) ? 32'hFFFF_FFFF : 32'(100 + i),
				32'hFFFF_FFFF, i[0] ? 8'd255 : 8'd24, 3'(i));
		// A full table with every time at the top value gives up slot zero.
		queue_op(ntae_pkg::FUNC_BEACON, 32'd200, 32'd5, 8'd24, 3'd0);
		queue_op(ntae_pkg::FUNC_BEACON, 32'd101, 32'd7, 8'd100, 3'd0);
		queue_op(ntae_pkg::FUNC_FIND, 32'hFFFF_FFFF, 32'd0, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_READ, 32'd0, 32'd0, 8'd0, 3'd7);
		queue_op(ntae_pkg::FUNC_BEACON, 32'd300, 32'd9, 8'd24, 3'd0);
		// An age equal to the timeout survives; the wrapped ages do not.
		queue_op(ntae_pkg::FUNC_TICK, 32'd0, 32'd30009, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_READ, 32'd0, 32'd0, 8'd0, 3'd0);
		queue_op(ntae_pkg::FUNC_TICK, 32'd0, 32'd30010, 8'd0, 3'd0);
		drain();

		reg_write(ntae_pkg::REG_OWN_ID, 32'hFFFF_FFFF);
		reg_write(ntae_pkg::REG_TIMEOUT, 32'd0);
		random_phase(130, 32'd2);

		calm = 1'b1;
		reg_write(ntae_pkg::REG_OWN_ID, $urandom);
		reg_write(ntae_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		random_phase(130, 32'd1000000);
		calm = 1'b0;

		reg_write(ntae_pkg::REG_OWN_ID, 32'd0);
		reg_write(ntae_pkg::REG_TIMEOUT, 32'd1000);
		hold_req = 1'b1;
		random_phase(130, 32'd400);

		reg_write(ntae_pkg::REG_OWN_ID, $urandom_range(1, 40));
		reg_write(ntae_pkg::REG_TIMEOUT, $urandom_range(500, 5000));
		random_phase(130, 32'd1500);

		reg_write(ntae_pkg::REG_OWN_ID, 32'd7);
		reg_write(ntae_pkg::REG_TIMEOUT, ntae_pkg::TIMEOUT_RESET);
		hold_req = 1'b1;
		random_phase(130, 32'd8000);

		reg_write(ntae_pkg::REG_TIMEOUT, $urandom);
		random_phase(130, 32'h8000_0000);

		if (errors == 0)
			$display("PASS neighbor_table_aging_eviction_unit");
		else
			$display("FAIL neighbor_table_aging_eviction_unit");
		$finish;
	end

endmodule
